>>> design/evd_pkg.sv
`default_nettype none

package evd_pkg;

  // encoding byte fields
  localparam logic [7:0] EncOmit  = 8'hFF;
  localparam logic [7:0] FmtMask  = 8'h0F;
  localparam logic [7:0] RelMask  = 8'h70;
  localparam logic [7:0] RelNone  = 8'h00;
  localparam logic [7:0] RelPc    = 8'h10;
  localparam int unsigned IndirBit = 7;

  // value formats
  localparam logic [3:0] FmtAbsptr = 4'h0;
  localparam logic [3:0] FmtUleb   = 4'h1;
  localparam logic [3:0] FmtUdata2 = 4'h2;
  localparam logic [3:0] FmtUdata4 = 4'h3;
  localparam logic [3:0] FmtUdata8 = 4'h4;
  localparam logic [3:0] FmtSleb   = 4'h9;
  localparam logic [3:0] FmtSdata2 = 4'hA;
  localparam logic [3:0] FmtSdata4 = 4'hB;
  localparam logic [3:0] FmtSdata8 = 4'hC;

  // leb byte fields
  localparam logic [7:0] LebPayload = 8'h7F;
  localparam int unsigned LebMoreBit = 7;
  localparam int unsigned LebSignBit = 6;
  localparam logic [3:0] LebMaxBytes = 4'd10;

  // queue depth
  localparam int unsigned QueueDepth = 2;

  // kinds of queued beats
  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_START = 2'd1,
    KIND_OMIT  = 2'd2,
    KIND_FAULT = 2'd3
  } kind_e;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        value_start;
    logic [7:0]  encoding;
    logic [63:0] base_address;
  } in_beat_t;

  typedef struct packed {
    logic [63:0] decoded_value;
    logic [3:0]  bytes_used;
    logic        needs_indirection;
    logic        fault;
  } out_beat_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data_byte;
    logic [7:0]  encoding;
    logic [63:0] base_address;
  } entry_t;

  // queue status toward the front
  typedef struct packed {
    logic full;
  } q_status_t;

  // byte length of a fixed format, 0 for leb formats
  function automatic logic [3:0] fmt_len(input logic [3:0] fmt);
    logic [3:0] len;
    case (fmt)
      FmtAbsptr: len = 4'd8;
      FmtUdata2: len = 4'd2;
      FmtUdata4: len = 4'd4;
      FmtUdata8: len = 4'd8;
      FmtSdata2: len = 4'd2;
      FmtSdata4: len = 4'd4;
      FmtSdata8: len = 4'd8;
      default:   len = 4'd0;
    endcase
    return len;
  endfunction

  // format is one the decoder knows
  function automatic logic fmt_ok(input logic [3:0] fmt);
    logic ok;
    case (fmt)
      FmtAbsptr, FmtUleb, FmtUdata2, FmtUdata4, FmtUdata8,
      FmtSleb, FmtSdata2, FmtSdata4, FmtSdata8: ok = 1'b1;
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

endpackage

`default_nettype wire

>>> design/evd_front.sv
`default_nettype none

module evd_front (
  input  wire logic              in_valid_i,
  input  wire evd_pkg::in_beat_t in_beat_i,
  input  wire evd_pkg::q_status_t q_status_i,
  output logic                   in_stall_o,
  output logic                   push_o,
  output evd_pkg::entry_t        entry_o
);
  import evd_pkg::*;

  logic [7:0] rel;
  logic       bad;

  // classify the incoming beat
  always_comb begin
    rel = in_beat_i.encoding & RelMask;
    bad = !fmt_ok(in_beat_i.encoding[3:0]) || ((rel != RelNone) && (rel != RelPc));
    entry_o.data_byte    = in_beat_i.data_byte;
    entry_o.encoding     = in_beat_i.encoding;
    entry_o.base_address = in_beat_i.base_address;
    if (!in_beat_i.value_start) begin
      entry_o.kind = KIND_BYTE;
    end else if (in_beat_i.encoding == EncOmit) begin
      entry_o.kind = KIND_OMIT;
    end else if (bad) begin
      entry_o.kind = KIND_FAULT;
    end else begin
      entry_o.kind = KIND_START;
    end
  end

  // accept while the queue has room
  assign in_stall_o = q_status_i.full;
  assign push_o     = in_valid_i && !q_status_i.full;

endmodule

`default_nettype wire

>>> design/evd_queue.sv
`default_nettype none

module evd_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire evd_pkg::entry_t  entry_i,
  input  wire logic             pop_i,
  output logic                  avail_o,
  output evd_pkg::entry_t       entry_o,
  output evd_pkg::q_status_t    status_o
);
  import evd_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  entry_t            slot_q [QueueDepth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              do_pop;

  assign avail_o       = (cnt_q != '0);
  assign status_o.full = (cnt_q == CntW'(QueueDepth));
  assign entry_o       = slot_q[rd_ptr_q];
  assign do_pop        = pop_i && avail_o;

  // pointer and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push_i, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

`default_nettype wire

>>> design/evd_back.sv
`default_nettype none

module evd_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             avail_i,
  input  wire evd_pkg::entry_t  entry_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output evd_pkg::out_beat_t    out_beat_o
);
  import evd_pkg::*;

  logic        busy_q, busy_d;
  logic [63:0] acc_q, acc_d;
  logic [6:0]  shift_q, shift_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [7:0]  enc_q, enc_d;
  logic [63:0] base_q, base_d;
  logic        out_valid_q, out_valid_d;
  out_beat_t   out_q, out_d;

  logic        step;
  logic        active;
  logic [63:0] acc_s;
  logic [6:0]  shift_s;
  logic [3:0]  cnt_s;
  logic [7:0]  enc_s;
  logic [63:0] base_s;
  logic [3:0]  fmt;
  logic [3:0]  len;
  logic        leb;
  logic [7:0]  payload;
  logic        done;

  // take an entry when the output register is free or draining
  assign step  = avail_i && (!out_valid_q || !out_stall_i);
  assign pop_o = step;

  always_comb begin
    // working copy: a start reloads the value state
    if (entry_i.kind == KIND_START) begin
      active  = 1'b1;
      acc_s   = '0;
      shift_s = '0;
      cnt_s   = '0;
      enc_s   = entry_i.encoding;
      base_s  = entry_i.base_address;
    end else begin
      active  = (entry_i.kind == KIND_BYTE) && busy_q;
      acc_s   = acc_q;
      shift_s = shift_q;
      cnt_s   = cnt_q;
      enc_s   = enc_q;
      base_s  = base_q;
    end
    fmt     = enc_s[3:0];
    len     = fmt_len(fmt);
    leb     = (len == 4'd0);
    payload = leb ? (entry_i.data_byte & LebPayload) : entry_i.data_byte;

    // gather one byte
    if (!shift_s[6]) begin
      acc_s = acc_s | ({56'd0, payload} << shift_s[5:0]);
    end
    shift_s = shift_s + (leb ? 7'd7 : 7'd8);
    cnt_s   = cnt_s + 4'd1;
    if (leb) begin
      done = !entry_i.data_byte[LebMoreBit] || (cnt_s >= LebMaxBytes);
    end else begin
      done = (cnt_s >= len);
    end

    // sign extension on the last byte
    if (done && leb && (fmt == FmtSleb) && entry_i.data_byte[LebSignBit] && !shift_s[6]) begin
      acc_s = acc_s | ({64{1'b1}} << shift_s[5:0]);
    end
    if (done && (fmt == FmtSdata2) && acc_s[15]) begin
      acc_s[63:16] = '1;
    end
    if (done && (fmt == FmtSdata4) && acc_s[31]) begin
      acc_s[63:32] = '1;
    end

    busy_d      = busy_q;
    acc_d       = acc_q;
    shift_d     = shift_q;
    cnt_d       = cnt_q;
    enc_d       = enc_q;
    base_d      = base_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;

    if (step) begin
      case (entry_i.kind)
        KIND_OMIT, KIND_FAULT: begin
          busy_d      = 1'b0;
          out_valid_d = 1'b1;
          out_d       = '0;
          out_d.fault = (entry_i.kind == KIND_FAULT);
        end
        KIND_START, KIND_BYTE: begin
          if (active) begin
            acc_d   = acc_s;
            shift_d = shift_s;
            cnt_d   = cnt_s;
            enc_d   = enc_s;
            base_d  = base_s;
            busy_d  = !done;
            if (done) begin
              out_valid_d = 1'b1;
              out_d.decoded_value = ((enc_s & RelMask) == RelPc) ? acc_s + base_s : acc_s;
              out_d.bytes_used        = cnt_s;
              out_d.needs_indirection = enc_s[IndirBit];
              out_d.fault             = 1'b0;
            end
          end
        end
        default: begin
          busy_d = busy_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  // value state and output payload
  always_ff @(posedge clk_i) begin
    acc_q   <= acc_d;
    shift_q <= shift_d;
    cnt_q   <= cnt_d;
    enc_q   <= enc_d;
    base_q  <= base_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

endmodule

`default_nettype wire

>>> design/dwarf_encoded_value_decoder.sv
// a result leaves the beat carrying its value's last byte through the input queue, then through
// the decode stage into the output register
// throughput: one byte beat per cycle while the output is not stalled, set by the gather step of the back end
// omit and unsupported encodings give their result from the start beat alone
// reset clears the queue, the in-progress flag and the output valid; no value is in progress
`default_nettype none

module dwarf_encoded_value_decoder (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire evd_pkg::in_beat_t  in_beat_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output evd_pkg::out_beat_t      out_beat_o
);
  import evd_pkg::*;

  logic      push;
  logic      pop;
  logic      avail;
  entry_t    front_entry;
  entry_t    queue_entry;
  q_status_t q_status;

  // classify incoming beats
  evd_front u_front (
    .in_valid_i (in_valid_i),
    .in_beat_i  (in_beat_i),
    .q_status_i (q_status),
    .in_stall_o (in_stall_o),
    .push_o     (push),
    .entry_o    (front_entry)
  );

  // short queue between front and back
  evd_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .entry_i  (front_entry),
    .pop_i    (pop),
    .avail_o  (avail),
    .entry_o  (queue_entry),
    .status_o (q_status)
  );

  // gather bytes and build results
  evd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .avail_i     (avail),
    .entry_i     (queue_entry),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_beat_o  (out_beat_o)
  );

endmodule

`default_nettype wire

>>> tb/tb_dwarf_encoded_value_decoder.sv
`timescale 1ns / 100ps

module tb_dwarf_encoded_value_decoder;
  import evd_pkg::*;

  localparam int unsigned RandomItems = 330;
  localparam int unsigned DrainLimit  = 20000;
  localparam int unsigned PrintLimit  = 50;

  // encodings the decoder must reject
  localparam logic [7:0] RelDatarel = 8'h30;
  localparam logic [7:0] RelAligned = 8'h50;
  localparam logic [3:0] FmtBadLow  = 4'h5;
  localparam logic [3:0] FmtBadTop  = 4'hF;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_PERIODIC,
    STALL_HEAVY
  } stall_mode_e;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_beat_t  in_beat_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_beat_t out_beat_o;

  dwarf_encoded_value_decoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_beat_i   (in_beat_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_beat_o  (out_beat_o)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // decoder state mirror
  logic [63:0] acc_q   = '0;
  logic [6:0]  shift_q = '0;
  logic [3:0]  count_q = '0;
  logic [7:0]  enc_q   = '0;
  logic [63:0] base_q  = '0;
  logic        busy_q  = 1'b0;

  out_beat_t   pending_decodes[$];
  out_beat_t   want_beat;
  logic [7:0]  value_bytes[$];
  int unsigned error_count = 0;
  int unsigned items_sent  = 0;
  int unsigned burst_left  = 0;
  int unsigned gap_max     = 0;

  stall_mode_e stall_mode  = STALL_NONE;
  int unsigned stall_timer = 0;

  task automatic report_mismatch(input string msg);
    if (error_count < PrintLimit) $display("%0t ns: %s", $time, msg);
    error_count++;
  endtask

  // byte count of a fixed format, 0 for leb, -1 when unknown
  function automatic int fixed_bytes(input logic [3:0] fmt);
    case (fmt)
      FmtAbsptr, FmtUdata8, FmtSdata8: return 8;
      FmtUdata4, FmtSdata4:            return 4;
      FmtUdata2, FmtSdata2:            return 2;
      FmtUleb, FmtSleb:                return 0;
      default:                         return -1;
    endcase
  endfunction

  // advance the mirror by one accepted beat and queue any result
  task automatic decode_beat(input in_beat_t beat);
    int          len;
    logic        done;
    logic [63:0] value;
    out_beat_t   res;
    res = '0;
    if (beat.value_start) begin
      enc_q   = beat.encoding;
      base_q  = beat.base_address;
      acc_q   = '0;
      shift_q = '0;
      count_q = '0;
      busy_q  = 1'b0;
      if (beat.encoding == EncOmit) begin
        pending_decodes.push_back(res);
        return;
      end
      if (fixed_bytes(beat.encoding[3:0]) < 0 ||
          ((beat.encoding & RelMask) != RelNone && (beat.encoding & RelMask) != RelPc)) begin
        res.fault = 1'b1;
        pending_decodes.push_back(res);
        return;
      end
      busy_q = 1'b1;
    end
    if (!busy_q) return;

    len = fixed_bytes(enc_q[3:0]);
    if (len == 0) begin
      // leb: seven payload bits per byte, anything past bit 63 dropped
      if (shift_q < 7'd64) acc_q |= {57'd0, beat.data_byte[6:0]} << shift_q;
      shift_q += 7'd7;
      count_q += 4'd1;
      done = !beat.data_byte[LebMoreBit] || count_q >= LebMaxBytes;
      if (done && enc_q[3:0] == FmtSleb && beat.data_byte[LebSignBit] && shift_q < 7'd64)
        acc_q |= ~64'd0 << shift_q;
    end else begin
      // fixed width little-endian
      if (shift_q < 7'd64) acc_q |= {56'd0, beat.data_byte} << shift_q;
      shift_q += 7'd8;
      count_q += 4'd1;
      done = count_q >= len;
      if (done && enc_q[3:0] == FmtSdata2 && acc_q[15]) acc_q |= ~64'hFFFF;
      if (done && enc_q[3:0] == FmtSdata4 && acc_q[31]) acc_q |= ~64'hFFFF_FFFF;
    end
    if (!done) return;

    value = acc_q;
    if ((enc_q & RelMask) == RelPc) value += base_q;
    res.decoded_value     = value;
    res.bytes_used        = count_q;
    res.needs_indirection = enc_q[IndirBit];
    pending_decodes.push_back(res);
    busy_q = 1'b0;
  endtask

  // predict on accepted input beats, check accepted output beats
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) decode_beat(in_beat_i);
      if (out_valid_o && !out_stall_i) begin
        if (pending_decodes.size() == 0) begin
          report_mismatch("result beat with nothing expected");
        end else begin
          want_beat = pending_decodes.pop_front();
          if (out_beat_o.decoded_value !== want_beat.decoded_value)
            report_mismatch($sformatf("decoded_value %h, want %h",
                                      out_beat_o.decoded_value, want_beat.decoded_value));
          if (out_beat_o.bytes_used !== want_beat.bytes_used)
            report_mismatch($sformatf("bytes_used %0d, want %0d",
                                      out_beat_o.bytes_used, want_beat.bytes_used));
          if (out_beat_o.needs_indirection !== want_beat.needs_indirection)
            report_mismatch($sformatf("needs_indirection %b, want %b",
                                      out_beat_o.needs_indirection,
                                      want_beat.needs_indirection));
          if (out_beat_o.fault !== want_beat.fault)
            report_mismatch($sformatf("fault %b, want %b",
                                      out_beat_o.fault, want_beat.fault));
        end
      end
    end
  end

  // receiver stall pattern, switching among random modes
  always @(posedge clk_i) begin
    if (stall_timer == 0) begin
      stall_mode  <= stall_mode_e'($urandom_range(0, 3));
      stall_timer <= $urandom_range(50, 300);
    end else begin
      stall_timer <= stall_timer - 1;
    end
    case (stall_mode)
      STALL_NONE:     out_stall_i <= 1'b0;
      STALL_LIGHT:    out_stall_i <= ($urandom_range(0, 3) == 0);
      STALL_PERIODIC: out_stall_i <= (stall_timer[2:0] < 3'd3);
      default:        out_stall_i <= ($urandom_range(0, 9) < 7);
    endcase
  end

  function automatic logic [63:0] rand_base();
    case ($urandom_range(0, 7))
      0:       return 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 255);
      1:       return {32'd0, $urandom};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [7:0] random_valid_enc();
    logic [7:0] enc;
    case ($urandom_range(0, 8))
      0:       enc = {4'h0, FmtAbsptr};
      1:       enc = {4'h0, FmtUleb};
      2:       enc = {4'h0, FmtUdata2};
      3:       enc = {4'h0, FmtUdata4};
      4:       enc = {4'h0, FmtUdata8};
      5:       enc = {4'h0, FmtSleb};
      6:       enc = {4'h0, FmtSdata2};
      7:       enc = {4'h0, FmtSdata4};
      default: enc = {4'h0, FmtSdata8};
    endcase
    if ($urandom_range(0, 1)) enc |= RelPc;
    enc[IndirBit] = 1'($urandom_range(0, 1));
    return enc;
  endfunction

  function automatic logic [7:0] random_bad_enc();
    logic [7:0] enc;
    do begin
      enc = 8'($urandom_range(0, 254));
    end while (fixed_bytes(enc[3:0]) >= 0 &&
               ((enc & RelMask) == RelNone || (enc & RelMask) == RelPc));
    return enc;
  endfunction

  // one input beat, with burst gaps, held until accepted
  task automatic send_beat(input in_beat_t beat);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_beat_i  <= beat;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // start beat carries enc and base, the rest of value_bytes follow
  task automatic send_value(input logic [7:0] enc, input logic [63:0] base);
    in_beat_t beat;
    if (value_bytes.size() == 0) value_bytes.push_back(8'($urandom_range(0, 255)));
    foreach (value_bytes[i]) begin
      beat.data_byte    = value_bytes[i];
      beat.value_start  = (i == 0);
      beat.encoding     = (i == 0) ? enc : 8'($urandom_range(0, 255));
      beat.base_address = (i == 0) ? base : rand_base();
      send_beat(beat);
    end
    items_sent += value_bytes.size();
    value_bytes.delete();
  endtask

  task automatic send_noise(input int unsigned count);
    in_beat_t beat;
    repeat (count) begin
      beat.data_byte    = 8'($urandom_range(0, 255));
      beat.value_start  = 1'b0;
      beat.encoding     = 8'($urandom_range(0, 255));
      beat.base_address = rand_base();
      send_beat(beat);
    end
  endtask

  // well-formed byte sequence for a supported encoding
  task automatic build_value(input logic [7:0] enc);
    int         len;
    int unsigned pick;
    logic [7:0] b;
    logic       all_ones;
    len = fixed_bytes(enc[3:0]);
    all_ones = ($urandom_range(0, 9) == 0);
    if (len == 0) begin
      pick = $urandom_range(0, 19);
      len = (pick < 12) ? $urandom_range(1, 3) :
            (pick < 18) ? $urandom_range(4, 10) : $urandom_range(11, 13);
      for (int i = 0; i < len; i++) begin
        b = all_ones ? 8'hFF : 8'($urandom_range(0, 255));
        b[LebMoreBit] = (i < len - 1);
        value_bytes.push_back(b);
      end
    end else begin
      for (int i = 0; i < len; i++)
        value_bytes.push_back(all_ones ? 8'hFF : 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic test_idle_bytes();
    in_beat_t beat;
    beat = '0;
    beat.data_byte = 8'hFF;
    send_beat(beat);
    beat.data_byte    = 8'h00;
    beat.encoding     = 8'hFF;
    beat.base_address = '1;
    send_beat(beat);
  endtask

  task automatic test_omit_and_fault();
    send_value(EncOmit, rand_base());
    send_value({4'h0, FmtBadLow}, rand_base());
    send_value(RelDatarel | {4'h0, FmtUdata4}, rand_base());
    send_value(RelAligned | {4'h0, FmtAbsptr}, rand_base());
    send_value({4'h8, FmtBadTop}, '1);
  endtask

  task automatic test_fixed_formats();
    value_bytes = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_value({4'h0, FmtAbsptr}, rand_base());
    value_bytes = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    send_value({4'h0, FmtAbsptr}, rand_base());
    value_bytes = '{8'h00, 8'h80};
    send_value({4'h0, FmtUdata2}, rand_base());
    value_bytes = '{8'h00, 8'h80};
    send_value({4'h0, FmtSdata2}, rand_base());
    value_bytes = '{8'hFF, 8'h7F};
    send_value({4'h0, FmtSdata2}, rand_base());
    value_bytes = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_value({4'h0, FmtUdata4}, rand_base());
    value_bytes = '{8'h00, 8'h00, 8'h00, 8'h80};
    send_value({4'h0, FmtSdata4}, rand_base());
    value_bytes = '{8'h01, 8'h23, 8'h45, 8'h67, 8'h89, 8'hAB, 8'hCD, 8'hEF};
    send_value({4'h0, FmtUdata8}, rand_base());
    value_bytes = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_value({4'h0, FmtSdata8}, rand_base());
  endtask

  task automatic test_leb_formats();
    value_bytes = '{8'h00};
    send_value({4'h0, FmtUleb}, rand_base());
    value_bytes = '{8'hE5, 8'h8E, 8'h26};
    send_value({4'h0, FmtUleb}, rand_base());
    value_bytes = '{8'h40};
    send_value({4'h0, FmtSleb}, rand_base());
    value_bytes = '{8'h3F};
    send_value({4'h0, FmtSleb}, rand_base());
    value_bytes = '{8'h80, 8'h7F};
    send_value({4'h0, FmtSleb}, rand_base());
    // continuation still set at the tenth byte, trailing bytes fall on an idle block
    repeat (12) value_bytes.push_back(8'hFF);
    send_value({4'h0, FmtUleb}, rand_base());
    // sign bit on the ninth byte fills only bit 63
    repeat (8) value_bytes.push_back(8'hFF);
    value_bytes.push_back(8'h7F);
    send_value({4'h0, FmtSleb}, rand_base());
    // ten bytes gather past bit 63, no sign fill
    repeat (9) value_bytes.push_back(8'hFF);
    value_bytes.push_back(8'h7F);
    send_value({4'h0, FmtSleb}, rand_base());
  endtask

  task automatic test_pc_relative();
    value_bytes = '{8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    send_value(RelPc | {4'h0, FmtUdata8}, 64'hFFFF_FFFF_FFFF_FFF0);
    value_bytes = '{8'hFC, 8'hFF, 8'hFF, 8'hFF};
    send_value(8'h80 | RelPc | {4'h0, FmtSdata4}, rand_base());
    value_bytes = '{8'h7F};
    send_value(RelPc | {4'h0, FmtSleb}, 64'h0000_0000_0000_0001);
    value_bytes = '{8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66, 8'h77, 8'h88};
    send_value(8'h80 | {4'h0, FmtAbsptr}, rand_base());
  endtask

  task automatic test_restart();
    value_bytes = '{8'h12, 8'h34, 8'h56, 8'h78};
    send_value({4'h0, FmtAbsptr}, rand_base());
    value_bytes = '{8'hAA, 8'hBB, 8'hCC, 8'hDD};
    send_value(RelPc | {4'h0, FmtUdata4}, rand_base());
    value_bytes = '{8'h81, 8'h82};
    send_value({4'h0, FmtUleb}, rand_base());
    send_value(EncOmit, rand_base());
  endtask

  // mostly well-formed values, some omit, faults, cut-off values and idle noise
  task automatic test_random_stream();
    int unsigned start_count;
    int unsigned pick;
    int unsigned cut;
    logic [7:0]  enc;
    start_count = items_sent;
    while (items_sent - start_count < RandomItems) begin
      case (((items_sent - start_count) / 90) % 3)
        0:       gap_max = 0;
        1:       gap_max = 4;
        default: gap_max = 12;
      endcase
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        enc = random_valid_enc();
        build_value(enc);
        send_value(enc, rand_base());
      end else if (pick < 78) begin
        send_value(EncOmit, rand_base());
      end else if (pick < 85) begin
        send_value(random_bad_enc(), rand_base());
      end else if (pick < 93) begin
        enc = random_valid_enc();
        build_value(enc);
        if (value_bytes.size() > 1) begin
          cut = $urandom_range(1, value_bytes.size() - 1);
          repeat (cut) void'(value_bytes.pop_back());
        end
        send_value(enc, rand_base());
      end else begin
        send_noise($urandom_range(1, 3));
      end
    end
  endtask

  initial begin
    int unsigned drain_cycles;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    gap_max = 2;
    test_idle_bytes();
    test_omit_and_fault();
    test_fixed_formats();
    test_leb_formats();
    test_pc_relative();
    test_restart();
    test_random_stream();
    in_valid_i <= 1'b0;

    // drain outstanding results
    drain_cycles = 0;
    while (pending_decodes.size() != 0 && drain_cycles < DrainLimit) begin
      @(posedge clk_i);
      drain_cycles++;
    end
    repeat (8) @(posedge clk_i);
    if (pending_decodes.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_decodes.size()));

    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // run limit
  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule
